// ===== rtl/lbr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbr_pkg
// shared types, constants and address helpers for the line/box/pixel rasterizer
// ----------------------------------------------------------------------------
package lbr_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 200;
  localparam int NUM_PIXELS   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(NUM_PIXELS);

  // field widths
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int COLOR_W = 24;
  localparam int COUNT_W = 16;
  localparam int MODE_W  = 2;
  // error term stays below four times the major length
  localparam int ERR_W   = X_W + 2;

  // register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_DRAW_MODE = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_BOX     = 2'd0,
    MODE_LINE    = 2'd1,
    MODE_PIXEL   = 2'd2,
    MODE_BOX_ALT = 2'd3
  } draw_mode_t;

  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_LINE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // one pixel on its way to the frame store
  typedef struct packed {
    logic           vld;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } plot_req_t;

  function automatic logic in_frame(logic [X_W-1:0] x, logic [Y_W-1:0] y);
    return (int'(x) < FRAME_WIDTH) && (int'(y) < FRAME_HEIGHT);
  endfunction

  // row-major address, meaningful only inside the frame
  function automatic logic [ADDR_W-1:0] pix_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
    return ADDR_W'(y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(x);
  endfunction

endpackage

// ===== rtl/line_box_pixel_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// line_box_pixel_rasterizer_unit
// draw engine over a 24-bit rgb frame store: pixels, lines, filled boxes, reads
// ----------------------------------------------------------------------------
// The block owns a 320x200 frame store of 24-bit pixels in one on-chip memory
// (one write port, one registered read port). After reset it sweeps the whole
// store to black, one pixel per clock, and accepts no transaction until the
// sweep is done; register writes are taken during that sweep. A draw
// transaction uses draw_mode: a single pixel, a line, or a filled box made of
// horizontal lines. Lines are walked along the major axis with an integer error
// term, one pixel per clock; the pixel goes through a registered write stage
// that forms the address and drops pixels outside the frame. A finished
// transaction waits for room in the result register before out_valid rises.
// One transaction is worked at a time; the result register lets the next
// transaction in while a result still waits to be taken.
// ----------------------------------------------------------------------------
module line_box_pixel_rasterizer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [lbr_pkg::X_W-1:0]           in_x_start,
  input  logic [lbr_pkg::Y_W-1:0]           in_y_start,
  input  logic [lbr_pkg::X_W-1:0]           in_x_end,
  input  logic [lbr_pkg::Y_W-1:0]           in_y_end,
  input  logic [lbr_pkg::COLOR_W-1:0]       in_color,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lbr_pkg::COLOR_W-1:0]       out_read_color,
  output logic [lbr_pkg::COUNT_W-1:0]       out_pixels_written,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lbr_pkg::APB_AW-1:0]        paddr,
  input  logic [lbr_pkg::APB_DW-1:0]        pwdata,
  output logic [lbr_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  // --------------------------------------------------------------------------
  // register file
  // --------------------------------------------------------------------------
  lbr_pkg::draw_mode_t draw_mode_r;
  logic                reg_hit;

  assign reg_hit = (paddr[lbr_pkg::APB_AW-1:2] == lbr_pkg::REG_DRAW_MODE);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? lbr_pkg::APB_DW'(draw_mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_mode_r <= lbr_pkg::MODE_BOX;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      draw_mode_r <= lbr_pkg::draw_mode_t'(pwdata[lbr_pkg::MODE_W-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  lbr_pkg::state_t state_r, state_nxt;
  logic [lbr_pkg::ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // latched transaction
  lbr_pkg::cmd_t               cmd_r;
  logic [lbr_pkg::X_W-1:0]     xs_r, xe_r;
  logic [lbr_pkg::Y_W-1:0]     ys_r, ye_r;
  logic [lbr_pkg::COLOR_W-1:0] color_r;
  logic [lbr_pkg::Y_W-1:0]     row_r, row_nxt;

  // walk registers
  logic [lbr_pkg::X_W-1:0]   wx_r, wx_nxt;
  logic [lbr_pkg::Y_W-1:0]   wy_r, wy_nxt;
  logic [lbr_pkg::X_W-1:0]   wi_r, wi_nxt;
  logic [lbr_pkg::X_W-1:0]   wl_r, wl_nxt;
  logic [lbr_pkg::ERR_W-1:0] wn2_r, wn2_nxt;
  logic [lbr_pkg::ERR_W-1:0] wd2_r, wd2_nxt;
  logic [lbr_pkg::ERR_W-1:0] werr_r, werr_nxt;
  logic                      ymaj_r, ymaj_nxt;
  logic                      down_r, down_nxt;

  // write stage, pixel count and result
  lbr_pkg::plot_req_t          pl_r, pl_nxt;
  logic [lbr_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [lbr_pkg::COLOR_W-1:0] res_color_r, res_color_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [lbr_pkg::COLOR_W-1:0] out_color_r, out_color_nxt;
  logic [lbr_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  // frame store
  logic [lbr_pkg::COLOR_W-1:0] mem [lbr_pkg::NUM_PIXELS];
  logic [lbr_pkg::COLOR_W-1:0] rd_data_r;
  logic                        mem_we;
  logic [lbr_pkg::ADDR_W-1:0]  mem_waddr;
  logic [lbr_pkg::COLOR_W-1:0] mem_wdata;
  logic                        pl_write;

  // line setup terms
  logic                      is_box;
  logic [lbr_pkg::X_W-1:0]   lx0, lx1, xa, xb, dx, len, mnr;
  logic [lbr_pkg::Y_W-1:0]   ly0, ly1, ya, yb, ady;
  logic                      swap, down, xmaj;

  // walk step terms
  logic [lbr_pkg::ERR_W-1:0] err_sum;
  logic                      carry;
  logic [lbr_pkg::Y_W-1:0]   wy_step;
  logic [lbr_pkg::X_W-1:0]   step_x;
  logic [lbr_pkg::Y_W-1:0]   step_y;
  logic                      line_last;

  logic in_acc, slot_free;

  assign in_ready           = (state_r == lbr_pkg::ST_IDLE);
  assign in_acc             = in_valid && in_ready;
  assign slot_free          = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_read_color     = out_color_r;
  assign out_pixels_written = out_count_r;

  // --------------------------------------------------------------------------
  // line setup: order endpoints by column, pick the major axis
  // --------------------------------------------------------------------------
  always_comb begin
    is_box = (draw_mode_r == lbr_pkg::MODE_BOX) || (draw_mode_r == lbr_pkg::MODE_BOX_ALT);
    lx0    = xs_r;
    lx1    = xe_r;
    ly0    = is_box ? row_r : ys_r;
    ly1    = is_box ? row_r : ye_r;
    swap   = (lx0 > lx1);
    xa     = swap ? lx1 : lx0;
    ya     = swap ? ly1 : ly0;
    xb     = swap ? lx0 : lx1;
    yb     = swap ? ly0 : ly1;
    dx     = xb - xa;
    down   = (yb >= ya);
    ady    = down ? (yb - ya) : (ya - yb);
    // ties go to the x axis
    xmaj   = (dx >= lbr_pkg::X_W'(ady));
    len    = xmaj ? dx : lbr_pkg::X_W'(ady);
    mnr    = xmaj ? lbr_pkg::X_W'(ady) : dx;
  end

  // --------------------------------------------------------------------------
  // walk step: error term holds 2*i*n + d - 2*d*off, kept in [0, 2d)
  // --------------------------------------------------------------------------
  always_comb begin
    err_sum   = werr_r + wn2_r;
    carry     = (err_sum >= wd2_r);
    wy_step   = down_r ? (wy_r + 1'b1) : (wy_r - 1'b1);
    if (ymaj_r) begin
      step_x = wx_r + lbr_pkg::X_W'(carry);
      step_y = wy_step;
    end else begin
      step_x = wx_r + 1'b1;
      step_y = carry ? wy_step : wy_r;
    end
    line_last = ((wi_r + 1'b1) == wl_r);
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    row_nxt       = row_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    wi_nxt        = wi_r;
    wl_nxt        = wl_r;
    wn2_nxt       = wn2_r;
    wd2_nxt       = wd2_r;
    werr_nxt      = werr_r;
    ymaj_nxt      = ymaj_r;
    down_nxt      = down_r;
    pl_nxt        = '0;
    res_color_nxt = res_color_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_color_nxt = out_color_r;
    out_count_nxt = out_count_r;

    unique case (state_r)
      lbr_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == lbr_pkg::ADDR_W'(lbr_pkg::NUM_PIXELS - 1)) begin
          state_nxt = lbr_pkg::ST_IDLE;
        end
      end
      lbr_pkg::ST_IDLE: begin
        if (in_acc) begin
          row_nxt       = in_y_start;
          res_color_nxt = '0;
          state_nxt     = lbr_pkg::ST_START;
        end
      end
      lbr_pkg::ST_START: begin
        if (cmd_r == lbr_pkg::CMD_READ) begin
          // frame store read is in flight this cycle
          state_nxt = lbr_pkg::ST_READ;
        end else if (draw_mode_r == lbr_pkg::MODE_PIXEL) begin
          pl_nxt    = '{vld: 1'b1, x: xs_r, y: ys_r};
          state_nxt = lbr_pkg::ST_FINISH;
        end else if (is_box && (ys_r > ye_r)) begin
          state_nxt = lbr_pkg::ST_FINISH;
        end else begin
          state_nxt = lbr_pkg::ST_LINE;
        end
      end
      lbr_pkg::ST_READ: begin
        res_color_nxt = lbr_pkg::in_frame(xs_r, ys_r) ? rd_data_r : '0;
        state_nxt     = lbr_pkg::ST_FINISH;
      end
      lbr_pkg::ST_LINE: begin
        // start pixel first, then set up the walk
        pl_nxt   = '{vld: 1'b1, x: lx0, y: ly0};
        wx_nxt   = xa;
        wy_nxt   = ya;
        wi_nxt   = '0;
        wl_nxt   = len;
        wn2_nxt  = lbr_pkg::ERR_W'({mnr, 1'b0});
        wd2_nxt  = lbr_pkg::ERR_W'({len, 1'b0});
        werr_nxt = lbr_pkg::ERR_W'(len);
        ymaj_nxt = !xmaj;
        down_nxt = down;
        if (len == '0) begin
          if (is_box && (row_r != ye_r)) begin
            row_nxt = row_r + 1'b1;
          end else begin
            state_nxt = lbr_pkg::ST_FINISH;
          end
        end else begin
          state_nxt = lbr_pkg::ST_WALK;
        end
      end
      lbr_pkg::ST_WALK: begin
        pl_nxt   = '{vld: 1'b1, x: step_x, y: step_y};
        wx_nxt   = step_x;
        wy_nxt   = step_y;
        wi_nxt   = wi_r + 1'b1;
        werr_nxt = carry ? (err_sum - wd2_r) : err_sum;
        if (line_last) begin
          if (is_box && (row_r != ye_r)) begin
            row_nxt   = row_r + 1'b1;
            state_nxt = lbr_pkg::ST_LINE;
          end else begin
            state_nxt = lbr_pkg::ST_FINISH;
          end
        end
      end
      lbr_pkg::ST_FINISH: begin
        // wait for the last pixel to land and for room in the result register
        if (!pl_r.vld && slot_free) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = res_color_r;
          out_count_nxt = count_r;
          state_nxt     = lbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lbr_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // write stage: address, frame check, saturating pixel count
  // --------------------------------------------------------------------------
  always_comb begin
    pl_write = pl_r.vld && lbr_pkg::in_frame(pl_r.x, pl_r.y);
    if (state_r == lbr_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = pl_write;
      mem_waddr = lbr_pkg::pix_addr(pl_r.x, pl_r.y);
      mem_wdata = color_r;
    end
    count_nxt = count_r;
    if (in_acc) begin
      count_nxt = '0;
    end else if (pl_write && (count_r != '1)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[lbr_pkg::pix_addr(xs_r, ys_r)];
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbr_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      pl_r        <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pl_r        <= pl_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= lbr_pkg::cmd_t'(in_cmd);
      xs_r    <= in_x_start;
      ys_r    <= in_y_start;
      xe_r    <= in_x_end;
      ye_r    <= in_y_end;
      color_r <= in_color;
    end
    row_r       <= row_nxt;
    wx_r        <= wx_nxt;
    wy_r        <= wy_nxt;
    wi_r        <= wi_nxt;
    wl_r        <= wl_nxt;
    wn2_r       <= wn2_nxt;
    wd2_r       <= wd2_nxt;
    werr_r      <= werr_nxt;
    ymaj_r      <= ymaj_nxt;
    down_r      <= down_nxt;
    res_color_r <= res_color_nxt;
    out_color_r <= out_color_nxt;
    out_count_r <= out_count_nxt;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_plot_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbr_pkg::ST_CLEAR) |-> !pl_r.vld)
    else $error("pixel write during clearing sweep");

  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!pl_r.vld && (count_r == count_nxt || count_nxt == '0)))
    else $error("transaction accepted with pixel write pending");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbr_pkg::ST_WALK) |-> (wi_r < wl_r))
    else $error("line walk ran past its length");

  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbr_pkg::ST_WALK) |-> (werr_r < wd2_r))
    else $error("line error term out of range");

  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> ($past(state_r) == lbr_pkg::ST_FINISH))
    else $error("result raised outside finish");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the line/box/pixel rasterizer draw engine
// ----------------------------------------------------------------------------
// Commands go in through a valid/ready driver fed from a queue, and results
// come back through a monitor that checks them in order. A behavioral copy of
// the frame store and the draw mode predicts every result at the moment its
// command is accepted. A short directed pass covers the frame corners,
// out-of-frame writes and reads, the ignored and masked register writes,
// reversed, degenerate and tie-rounding lines, empty and reversed boxes and a
// full-screen box. Random phases follow, each under its own draw mode. Random
// command-side gaps and result-side stalls run throughout, but for one phase in
// four the gaps are off and for another the stalls are off.
// ----------------------------------------------------------------------------
module tb_top;
  import lbr_pkg::*;

  // run shape
  localparam int RANDOM_ITEMS  = 950;
  localparam int RANDOM_PHASES = 8;
  localparam int SETTLE_CYCLES = 16;
  // room for the reset sweep and the largest box, which both run with no transaction
  localparam int IDLE_LIMIT    = 600000;
  localparam int COUNT_CAP     = 65535;
  localparam int X_TOP         = (1 << X_W) - 1;
  localparam int Y_TOP         = (1 << Y_W) - 1;

  // register addresses, one 32-bit word per register
  localparam logic [APB_AW-1:0] ADDR_DRAW_MODE = {REG_DRAW_MODE, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED  = {~REG_DRAW_MODE, 2'b00};

  // one command transaction
  typedef struct packed {
    cmd_t               cmd;
    logic [X_W-1:0]     xs;
    logic [Y_W-1:0]     ys;
    logic [X_W-1:0]     xe;
    logic [Y_W-1:0]     ye;
    logic [COLOR_W-1:0] color;
  } draw_req_t;

  // one result transaction
  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic [COUNT_W-1:0] pixels_written;
  } pix_result_t;

  // every input has a known value from time zero
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_cmd = 1'b0;
  logic [X_W-1:0]      in_x_start = '0;
  logic [Y_W-1:0]      in_y_start = '0;
  logic [X_W-1:0]      in_x_end = '0;
  logic [Y_W-1:0]      in_y_end = '0;
  logic [COLOR_W-1:0]  in_color = '0;
  logic                out_ready = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic                in_ready;
  logic                out_valid;
  logic [COLOR_W-1:0]  out_read_color;
  logic [COUNT_W-1:0]  out_pixels_written;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // commands waiting to be sent and results waiting to arrive
  draw_req_t           req_queue[$];
  pix_result_t         result_q[$];
  // recently drawn coordinates, so that reads land on painted pixels
  logic [X_W+Y_W-1:0]  recent_spots[$];

  // predicted frame store and register state
  logic [COLOR_W-1:0]  frame_model [NUM_PIXELS];
  draw_mode_t          model_mode;
  int                  plot_count;

  int                  fail_count = 0;
  int                  quiet_cycles = 0;
  int                  send_gap = 0;
  int                  stall_left = 0;
  bit                  sender_gaps = 1'b1;
  bit                  receiver_stalls = 1'b1;

  line_box_pixel_rasterizer_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_x_start         (in_x_start),
    .in_y_start         (in_y_start),
    .in_x_end           (in_x_end),
    .in_y_end           (in_y_end),
    .in_color           (in_color),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_color     (out_read_color),
    .out_pixels_written (out_pixels_written),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // in-frame writes land in the store and count, saturating
  function automatic void put_pixel(int x, int y, logic [COLOR_W-1:0] c);
    if (x < FRAME_WIDTH && y < FRAME_HEIGHT) begin
      frame_model[y * FRAME_WIDTH + x] = c;
      if (plot_count < COUNT_CAP) plot_count++;
    end
  endfunction

  // start pixel first, then a walk from the left endpoint along the major
  // axis; the minor offset is rounded exactly, halves away from the walk start
  function automatic void trace_line(int x0, int y0, int x1, int y1,
                                     logic [COLOR_W-1:0] c);
    int  xa, ya, xb, yb, dx, ady, off;
    bit  down;
    put_pixel(x0, y0, c);
    if (x0 > x1) begin
      xa = x1; ya = y1; xb = x0; yb = y0;
    end else begin
      xa = x0; ya = y0; xb = x1; yb = y1;
    end
    dx   = xb - xa;
    down = (yb >= ya);
    ady  = down ? (yb - ya) : (ya - yb);
    if (dx >= ady) begin
      for (int i = 1; i <= dx; i++) begin
        off = (2 * i * ady + dx) / (2 * dx);
        put_pixel(xa + i, down ? ya + off : ya - off, c);
      end
    end else begin
      for (int i = 1; i <= ady; i++) begin
        off = (2 * i * dx + ady) / (2 * ady);
        put_pixel(xa + off, down ? ya + i : ya - i, c);
      end
    end
  endfunction

  // applies one command to the predicted store and returns its result
  function automatic pix_result_t predict_result(draw_req_t r);
    pix_result_t res;
    res = '0;
    plot_count = 0;
    if (r.cmd == CMD_READ) begin
      if (r.xs < FRAME_WIDTH && r.ys < FRAME_HEIGHT)
        res.read_color = frame_model[int'(r.ys) * FRAME_WIDTH + int'(r.xs)];
    end else begin
      case (model_mode)
        MODE_PIXEL: put_pixel(int'(r.xs), int'(r.ys), r.color);
        MODE_LINE:  trace_line(int'(r.xs), int'(r.ys), int'(r.xe), int'(r.ye), r.color);
        // box and its alias: one horizontal line per row, none if reversed
        default: begin
          for (int row = int'(r.ys); row <= int'(r.ye); row++)
            trace_line(int'(r.xs), row, int'(r.xe), row, r.color);
        end
      endcase
      res.pixels_written = COUNT_W'(plot_count);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // columns: mostly in frame, some edges, some beyond the right border
  function automatic int pick_col();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return $urandom_range(FRAME_WIDTH, X_TOP);
    if (r < 12) return $urandom_range(0, 1) ? FRAME_WIDTH - 1 : 0;
    return $urandom_range(0, FRAME_WIDTH - 1);
  endfunction

  function automatic int pick_row();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return $urandom_range(FRAME_HEIGHT, Y_TOP);
    if (r < 12) return $urandom_range(0, 1) ? FRAME_HEIGHT - 1 : 0;
    return $urandom_range(0, FRAME_HEIGHT - 1);
  endfunction

  // random command for the given mode: most boxes are small, a few span
  // anything; a third of the lines are short
  function automatic draw_req_t make_req(draw_mode_t mode);
    draw_req_t           r;
    int                  xs, ys, xe, ye, span, step;
    logic [X_W+Y_W-1:0]  spot;
    xs = pick_col();
    ys = pick_row();
    xe = pick_col();
    ye = pick_row();
    r.color = COLOR_W'($urandom());
    if ($urandom_range(0, 99) < 30) begin
      r.cmd = CMD_READ;
      if (recent_spots.size() != 0 && $urandom_range(0, 3) != 0) begin
        spot = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
        xs = int'(spot[X_W+Y_W-1:Y_W]);
        ys = int'(spot[Y_W-1:0]);
      end
    end else begin
      r.cmd = CMD_DRAW;
      if ((mode == MODE_BOX || mode == MODE_BOX_ALT) && $urandom_range(0, 99) >= 2) begin
        span = $urandom_range(0, 40);
        xe = $urandom_range(0, 1) ? xs + span : xs - span;
        if ($urandom_range(0, 19) == 0) begin
          // empty box: end row above start row
          step = $urandom_range(1, 3);
          ye = ys - step;
        end else begin
          step = $urandom_range(0, 6);
          ye = ys + step;
        end
      end else if (mode == MODE_LINE && $urandom_range(0, 2) == 0) begin
        span = $urandom_range(0, 12);
        step = $urandom_range(0, 12);
        xe = xs + span - 6;
        ye = ys + step - 6;
      end
      if (xe < 0) xe = 0;
      if (xe > X_TOP) xe = X_TOP;
      if (ye < 0) ye = 0;
      if (ye > Y_TOP) ye = Y_TOP;
      recent_spots.push_back({X_W'(xs), Y_W'(ys)});
      recent_spots.push_back({X_W'(xe), Y_W'(ye)});
      while (recent_spots.size() > 16) void'(recent_spots.pop_front());
    end
    r.xs = X_W'(xs);
    r.ys = Y_W'(ys);
    r.xe = X_W'(xe);
    r.ye = Y_W'(ye);
    return r;
  endfunction

  task automatic queue_req(cmd_t c, int xs, int ys, int xe, int ye,
                           logic [COLOR_W-1:0] col);
    req_queue.push_back('{c, X_W'(xs), Y_W'(ys), X_W'(xe), Y_W'(ye), col});
  endtask

  // setup cycle, then access cycle; the write lands when pready is seen
  task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[APB_AW-1:2] == REG_DRAW_MODE) model_mode = draw_mode_t'(data[MODE_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // the test holds off until every queued command is answered, then lets the
  // engine settle so that it is surely back in idle
  task automatic wait_idle();
    do @(negedge clk); while (req_queue.size() != 0 || in_valid || result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // command driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_cmds
    draw_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      // slot is free: idle out the gap or present the next command
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (req_queue.size() != 0) begin
        nxt        = req_queue.pop_front();
        in_valid   <= 1'b1;
        in_cmd     <= nxt.cmd;
        in_x_start <= nxt.xs;
        in_y_start <= nxt.ys;
        in_x_end   <= nxt.xe;
        in_y_end   <= nxt.ye;
        in_color   <= nxt.color;
        send_gap   <= sender_gaps ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result-side back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on command acceptance, check on result acceptance,
  // watchdog on cycles with no transaction at all
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    pix_result_t want;
    draw_req_t   seen;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with nothing expected: read_color %h pixels_written %0d",
                   $time, out_read_color, out_pixels_written);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_read_color !== want.read_color) begin
            $display("%0t: read_color expected %h, actual %h",
                     $time, want.read_color, out_read_color);
            fail_count++;
          end
          if (out_pixels_written !== want.pixels_written) begin
            $display("%0t: pixels_written expected %0d, actual %0d",
                     $time, want.pixels_written, out_pixels_written);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        seen.cmd   = cmd_t'(in_cmd);
        seen.xs    = in_x_start;
        seen.ys    = in_y_start;
        seen.xe    = in_x_end;
        seen.ye    = in_y_end;
        seen.color = in_color;
        result_q.push_back(predict_result(seen));
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    draw_mode_t phase_modes [RANDOM_PHASES];
    phase_modes = '{MODE_LINE, MODE_PIXEL, MODE_BOX, MODE_BOX_ALT,
                    MODE_LINE, MODE_BOX, MODE_PIXEL, MODE_LINE};
    foreach (frame_model[i]) frame_model[i] = '0;
    model_mode = MODE_BOX;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // single pixels at the corners and just outside the frame; the write
    // lands during the clearing sweep
    reg_write(ADDR_DRAW_MODE, APB_DW'(MODE_PIXEL));
    queue_req(CMD_DRAW, 0, 0, X_TOP, Y_TOP, 24'hFFFFFF);
    queue_req(CMD_DRAW, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 0, 0, 24'h800001);
    queue_req(CMD_DRAW, FRAME_WIDTH, 0, 0, 0, 24'h00FF00);
    queue_req(CMD_DRAW, X_TOP, Y_TOP, 0, 0, 24'h000000);
    queue_req(CMD_DRAW, 0, FRAME_HEIGHT, 0, 0, 24'h0000FF);
    queue_req(CMD_READ, 0, 0, 0, 0, 24'h000000);
    queue_req(CMD_READ, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 0, 0, 24'hFFFFFF);
    // out-of-frame read and a read of a never-painted pixel both give black
    queue_req(CMD_READ, X_TOP, Y_TOP, 0, 0, 24'h000000);
    queue_req(CMD_READ, 10, 10, 0, 0, 24'h000000);
    wait_idle();

    // write to an unmapped address must leave pixel mode in place
    reg_write(ADDR_UNMAPPED, APB_DW'(MODE_LINE));
    queue_req(CMD_DRAW, 5, 5, 100, 100, 24'hA5A5A5);
    wait_idle();

    // upper bits of the mode write are dropped, leaving line mode
    reg_write(ADDR_DRAW_MODE, {{(APB_DW - MODE_W){1'b1}}, MODE_LINE});
    queue_req(CMD_DRAW, 0, 5, FRAME_WIDTH - 1, 5, 24'h112233);
    queue_req(CMD_DRAW, 40, 0, 40, FRAME_HEIGHT - 1, 24'h445566);
    // half-pixel tie steps away from the start
    queue_req(CMD_DRAW, 10, 10, 12, 11, 24'h778899);
    // reversed line: walk from the end point, start pixel written twice
    queue_req(CMD_DRAW, 100, 50, 90, 60, 24'hAABBCC);
    queue_req(CMD_DRAW, 7, 7, 7, 7, 24'hDDEEFF);
    queue_req(CMD_DRAW, 0, FRAME_HEIGHT - 1, 50, 0, 24'h0F0F0F);
    queue_req(CMD_DRAW, 300, 100, X_TOP, Y_TOP, 24'hF0F0F0);
    queue_req(CMD_READ, 11, 11, 0, 0, 24'h000000);
    wait_idle();

    // alias of box mode, reversed box and an empty box
    reg_write(ADDR_DRAW_MODE, APB_DW'(MODE_BOX_ALT));
    queue_req(CMD_DRAW, 20, 30, 10, 32, 24'h123123);
    queue_req(CMD_DRAW, 5, 9, 8, 7, 24'h321321);
    queue_req(CMD_READ, 15, 31, 0, 0, 24'h000000);
    wait_idle();

    // full-screen reversed box, then one hanging over the corner
    reg_write(ADDR_DRAW_MODE, APB_DW'(MODE_BOX));
    queue_req(CMD_DRAW, FRAME_WIDTH - 1, 0, 0, FRAME_HEIGHT - 1, 24'h123456);
    queue_req(CMD_READ, 160, 100, 0, 0, 24'h000000);
    queue_req(CMD_DRAW, 310, 195, 330, 210, 24'h654321);
    wait_idle();

    // random phases; each ends by draining, so the sender pauses until all
    // results are in before the next mode write
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      reg_write(ADDR_DRAW_MODE, APB_DW'(phase_modes[ph]));
      sender_gaps     = (ph % 4 != 3);
      receiver_stalls = (ph % 4 != 2);
      repeat (RANDOM_ITEMS / RANDOM_PHASES) req_queue.push_back(make_req(phase_modes[ph]));
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
